/* src/mame_pkg.sv */
// ----------------------------------------------------------------------------
// mame_pkg
// Shared types and constants of the matrix add / multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mame_pkg;

    // element data width
    localparam int DATA_W = 32;
    // width of a dimension register
    localparam int DIM_W = 4;
    // width of a row or column index on the ports
    localparam int IDX_W = 3;

    // input opcodes
    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_A_ROWS = 3'd0;
    localparam logic [2:0] CFG_A_COLS = 3'd1;
    localparam logic [2:0] CFG_B_ROWS = 3'd2;
    localparam logic [2:0] CFG_B_COLS = 3'd3;
    localparam logic [2:0] CFG_MODE   = 3'd4;

    // operation modes
    localparam logic MODE_SUM  = 1'b0;
    localparam logic MODE_PROD = 1'b1;

    // control tag that travels alongside each memory read
    typedef struct packed {
        logic             vld;       // a read was issued
        logic             err;       // dimension error beat
        logic             first;     // first term of an accumulation
        logic             last_k;    // last term, result is complete
        logic             last_all;  // final result of the run
        logic             mode;      // product when set
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    // clamp a dimension register to the store size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        eff_dim = (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

/* src/mame_mem.sv */
// ----------------------------------------------------------------------------
// mame_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mame_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [mame_pkg::DATA_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [mame_pkg::DATA_W-1:0] rdata
);
    import mame_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/mame_seq.sv */
// ----------------------------------------------------------------------------
// mame_seq
// Read sequencer: checks dimensions and walks the i, j, k loops, issuing one
// read pair and one control tag per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mame_seq #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       start,
    input  wire logic                       mode,
    input  wire logic [mame_pkg::DIM_W-1:0] a_rows,
    input  wire logic [mame_pkg::DIM_W-1:0] a_cols,
    input  wire logic [mame_pkg::DIM_W-1:0] b_rows,
    input  wire logic [mame_pkg::DIM_W-1:0] b_cols,
    output logic                            busy,
    output logic      [AW-1:0]              a_addr,
    output logic      [AW-1:0]              b_addr,
    output mame_pkg::tag_t                  tag
);
    import mame_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [DIM_W-1:0] LIM = DIM_W'(MAX_DIM);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [IW-1:0]    k_reg, k_next;

    logic [DIM_W-1:0] ar, ac, br, bc;
    logic [DIM_W-1:0] ocols, kcnt;
    logic             dims_ok;
    logic             last_i, last_j, last_k;
    logic [IW-1:0]    a_col, b_row;

    // effective dimensions and compatibility check
    always_comb
    begin
        ar = eff_dim(a_rows, LIM);
        ac = eff_dim(a_cols, LIM);
        br = eff_dim(b_rows, LIM);
        bc = eff_dim(b_cols, LIM);
        if (mode == MODE_PROD)
        begin
            dims_ok = (ac == br);
            ocols   = bc;
            kcnt    = ac;
        end
        else
        begin
            dims_ok = (ar == br) && (ac == bc);
            ocols   = ac;
            kcnt    = DIM_W'(1);
        end
        if (ar == '0 || ac == '0 || br == '0 || bc == '0)
        begin
            dims_ok = 1'b0;
        end
    end

    // loop end detection
    assign last_k = (DIM_W'(k_reg) + DIM_W'(1)) == kcnt;
    assign last_j = (DIM_W'(j_reg) + DIM_W'(1)) == ocols;
    assign last_i = (DIM_W'(i_reg) + DIM_W'(1)) == ar;

    // read addresses, row * MAX_DIM + col
    assign a_col  = (mode == MODE_PROD) ? k_reg : j_reg;
    assign b_row  = (mode == MODE_PROD) ? k_reg : i_reg;
    assign a_addr = AW'(int'(i_reg) * MAX_DIM + int'(a_col));
    assign b_addr = AW'(int'(b_row) * MAX_DIM + int'(j_reg));

    // control tag for the read issued this cycle
    always_comb
    begin
        tag.vld      = (state_reg != S_IDLE);
        tag.err      = (state_reg == S_ERR);
        tag.first    = (k_reg == '0) || tag.err;
        tag.last_k   = last_k || tag.err;
        tag.last_all = tag.err || (last_k && last_j && last_i);
        tag.mode     = mode;
        tag.row      = tag.err ? '0 : IDX_W'(i_reg);
        tag.col      = tag.err ? '0 : IDX_W'(j_reg);
    end

    assign busy = (state_reg != S_IDLE);

    // loop counters and state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = dims_ok ? S_RUN : S_ERR;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            S_RUN:
            begin
                if (en)
                begin
                    if (!last_k)
                    begin
                        k_next = IW'(k_reg + 1'b1);
                    end
                    else
                    begin
                        k_next = '0;
                        if (!last_j)
                        begin
                            j_next = IW'(j_reg + 1'b1);
                        end
                        else
                        begin
                            j_next = '0;
                            if (last_i)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                i_next = IW'(i_reg + 1'b1);
                            end
                        end
                    end
                end
            end
            S_ERR:
            begin
                if (en)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // final beat of a run always returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (en && tag.vld && tag.last_all) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after final beat");

    // error beat is a complete single result
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (tag.vld && tag.err) |-> (tag.first && tag.last_k && tag.last_all))
        else $error("error beat not marked as a single final result");

    // a run never ends in the middle of an accumulation
    a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
        (tag.vld && tag.last_all) |-> tag.last_k)
        else $error("final beat without a completed accumulation");

endmodule

`default_nettype wire

/* src/mame_dp.sv */
// ----------------------------------------------------------------------------
// mame_dp
// Datapath: aligns tags with read data, forms the product or sum, accumulates
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mame_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  mame_pkg::tag_t                          tag0,
    input  wire logic        [mame_pkg::DATA_W-1:0] a_rdata,
    input  wire logic        [mame_pkg::DATA_W-1:0] b_rdata,
    input  wire logic                               out_stall,
    output logic                                    en,
    output logic                                    out_valid,
    output logic signed      [mame_pkg::DATA_W-1:0] element_out,
    output logic             [mame_pkg::IDX_W-1:0]  out_row,
    output logic             [mame_pkg::IDX_W-1:0]  out_col,
    output logic                                    status,
    output logic                                    last_flag
);
    import mame_pkg::*;

    tag_t              tag1_reg, tag2_reg;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              out_vld_reg, out_vld_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic              out_err_reg, out_last_reg;
    logic              load_out;

    // whole pipeline moves when the output slot is free or being taken
    assign en = !out_vld_reg || !out_stall;

    // product or element sum, low 32 bits
    assign prod_next = (tag1_reg.mode == MODE_PROD) ? DATA_W'(a_rdata * b_rdata)
                                                    : DATA_W'(a_rdata + b_rdata);

    // accumulation
    assign acc_next = (tag2_reg.first ? '0 : acc_reg) + prod_reg;
    assign load_out = en && tag2_reg.vld && tag2_reg.last_k;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (en)
        begin
            out_vld_next = tag2_reg.vld && tag2_reg.last_k;
        end
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                tag1_reg <= tag0;
                tag2_reg <= tag1_reg;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
        if (en && tag2_reg.vld)
        begin
            acc_reg <= acc_next;
        end
        if (load_out)
        begin
            out_data_reg <= tag2_reg.err ? '0 : acc_next;
            out_row_reg  <= tag2_reg.row;
            out_col_reg  <= tag2_reg.col;
            out_err_reg  <= tag2_reg.err;
            out_last_reg <= tag2_reg.last_all;
        end
    end

    assign out_valid   = out_vld_reg;
    assign element_out = $signed(out_data_reg);
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign status      = out_err_reg;
    assign last_flag   = out_last_reg;

    // a stalled output freezes the accumulator
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(acc_reg))
        else $error("accumulator changed while the output was stalled");

    // error result is a single zero beat that closes the run
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_err_reg) |-> (out_last_reg && out_data_reg == '0))
        else $error("error result malformed");

    // sum mode has one term per result
    a_sum_single: assert property (@(posedge clk) disable iff (!rst_n)
        (tag2_reg.vld && tag2_reg.mode == MODE_SUM) |-> (tag2_reg.first && tag2_reg.last_k))
        else $error("sum mode beat with more than one term");

endmodule

`default_nettype wire

/* src/matrix_add_multiply_engine_unit.sv */
// Load beats are accepted back to back while idle.
// A compute beat holds in_stall while rows * cols * k read pairs are issued,
// k = a_cols in product mode and 1 in sum mode, one read pair per cycle unless
// the output stalls. Results pass the store read and product registers first.
// Reset sets dimensions 1 and sum mode and clears control; store contents
// are undefined until written.
// ----------------------------------------------------------------------------
// matrix_add_multiply_engine_unit
// Integer matrix sum and product engine built around two element stores.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_add_multiply_engine_unit #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic        [2:0]                  cfg_index,
    input  wire logic        [mame_pkg::DIM_W-1:0]  cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic        [1:0]                  opcode,
    input  wire logic        [mame_pkg::IDX_W-1:0]  row_index,
    input  wire logic        [mame_pkg::IDX_W-1:0]  col_index,
    input  wire logic signed [mame_pkg::DATA_W-1:0] element_in,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed      [mame_pkg::DATA_W-1:0] element_out,
    output logic             [mame_pkg::IDX_W-1:0]  out_row,
    output logic             [mame_pkg::IDX_W-1:0]  out_col,
    output logic                                    status,
    output logic                                    last_flag
);
    import mame_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic             mode_reg;

    logic             in_acc, start, busy, en, in_range;
    logic             we_a, we_b;
    logic [AW-1:0]    waddr, a_raddr, b_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata;
    tag_t             tag0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(1);
            a_cols_reg <= DIM_W'(1);
            b_rows_reg <= DIM_W'(1);
            b_cols_reg <= DIM_W'(1);
            mode_reg   <= MODE_SUM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A_ROWS: a_rows_reg <= cfg_data;
                CFG_A_COLS: a_cols_reg <= cfg_data;
                CFG_B_ROWS: b_rows_reg <= cfg_data;
                CFG_B_COLS: b_cols_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // input beat decode; busy keeps loads away from a running read sweep
    assign in_stall = busy;
    assign in_acc   = in_valid && !in_stall;
    assign start    = in_acc && (opcode == OP_COMPUTE);
    assign in_range = ({1'b0, row_index} < DIM_W'(MAX_DIM)) &&
                      ({1'b0, col_index} < DIM_W'(MAX_DIM));
    assign we_a     = in_acc && in_range && (opcode == OP_WR_A);
    assign we_b     = in_acc && in_range && (opcode == OP_WR_B);
    assign waddr    = AW'(int'(row_index) * MAX_DIM + int'(col_index));

    // element stores
    mame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata ($unsigned(element_in)),
        .re    (en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata ($unsigned(element_in)),
        .re    (en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // read sequencer
    mame_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .start  (start),
        .mode   (mode_reg),
        .a_rows (a_rows_reg),
        .a_cols (a_cols_reg),
        .b_rows (b_rows_reg),
        .b_cols (b_cols_reg),
        .busy   (busy),
        .a_addr (a_raddr),
        .b_addr (b_raddr),
        .tag    (tag0)
    );

    // arithmetic and output register
    mame_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag0        (tag0),
        .a_rdata     (a_rdata),
        .b_rdata     (b_rdata),
        .out_stall   (out_stall),
        .en          (en),
        .out_valid   (out_valid),
        .element_out (element_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .status      (status),
        .last_flag   (last_flag)
    );

endmodule

`default_nettype wire

/* tb/matrix_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_result_checker
// Watches the configuration port and both channels of the matrix engine.
// It keeps its own copy of the two element stores and of the dimension
// registers, and works out the result beats of every compute beat. Each
// result beat is compared field by field with the oldest one still owed.
// ----------------------------------------------------------------------------

module matrix_result_checker #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration port
    input  wire logic                                cfg_we,
    input  wire logic        [2:0]                   cfg_index,
    input  wire logic        [mame_pkg::DIM_W-1:0]   cfg_data,
    // input channel
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic        [1:0]                   opcode,
    input  wire logic        [mame_pkg::IDX_W-1:0]   row_index,
    input  wire logic        [mame_pkg::IDX_W-1:0]   col_index,
    input  wire logic signed [mame_pkg::DATA_W-1:0]  element_in,
    // output channel
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [mame_pkg::DATA_W-1:0]  element_out,
    input  wire logic        [mame_pkg::IDX_W-1:0]   out_row,
    input  wire logic        [mame_pkg::IDX_W-1:0]   out_col,
    input  wire logic                                status,
    input  wire logic                                last_flag,
    // to the testbench top
    output int                                       mismatch_count,
    output int                                       results_pending
);
    import mame_pkg::*;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIM_ERR = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] element;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              err;
        logic              last_beat;
    } matrix_result_t;

    logic [DATA_W-1:0] copy_a [MAX_DIM][MAX_DIM];
    logic [DATA_W-1:0] copy_b [MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0]  dim_a_rows;
    logic [DIM_W-1:0]  dim_a_cols;
    logic [DIM_W-1:0]  dim_b_rows;
    logic [DIM_W-1:0]  dim_b_cols;
    logic              prod_mode;

    matrix_result_t    owed_results[$];

    // register values past the store size behave as the store size
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // result beats of one compute run, in row-major order
    task automatic predict_compute();
        int             ar;
        int             ac;
        int             br;
        int             bc;
        int             n_rows;
        int             n_cols;
        bit             fits;
        logic [DATA_W-1:0] acc;
        matrix_result_t beat;
        ar = clamp_dim(dim_a_rows);
        ac = clamp_dim(dim_a_cols);
        br = clamp_dim(dim_b_rows);
        bc = clamp_dim(dim_b_cols);
        if (prod_mode == MODE_SUM)
        begin
            fits   = (ar == br) && (ac == bc);
            n_rows = ar;
            n_cols = ac;
        end
        else
        begin
            fits   = (ac == br);
            n_rows = ar;
            n_cols = bc;
        end
        if (ar == 0 || ac == 0 || br == 0 || bc == 0)
            fits = 1'b0;

        // shapes that do not suit the mode give one error beat
        if (!fits)
        begin
            beat.element   = '0;
            beat.row       = '0;
            beat.col       = '0;
            beat.err       = STATUS_DIM_ERR;
            beat.last_beat = 1'b1;
            owed_results.push_back(beat);
            return;
        end

        for (int i = 0; i < n_rows; i++)
        begin
            for (int j = 0; j < n_cols; j++)
            begin
                if (prod_mode == MODE_SUM)
                    acc = copy_a[i][j] + copy_b[i][j];
                else
                begin
                    // low 32 bits of each product, wrapped sum
                    acc = '0;
                    for (int k = 0; k < ac; k++)
                        acc += copy_a[i][k] * copy_b[k][j];
                end
                beat.element   = acc;
                beat.row       = i[IDX_W-1:0];
                beat.col       = j[IDX_W-1:0];
                beat.err       = STATUS_OK;
                beat.last_beat = (i == n_rows - 1) && (j == n_cols - 1);
                owed_results.push_back(beat);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // model state follows every config write and every beat
    always @(posedge clk or negedge rst_n)
    begin
        matrix_result_t want;
        if (!rst_n)
        begin
            dim_a_rows      = DIM_W'(1);
            dim_a_cols      = DIM_W'(1);
            dim_b_rows      = DIM_W'(1);
            dim_b_cols      = DIM_W'(1);
            prod_mode       = MODE_SUM;
            mismatch_count  = 0;
            results_pending = 0;
            owed_results.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_ROWS: dim_a_rows = cfg_data;
                    CFG_A_COLS: dim_a_cols = cfg_data;
                    CFG_B_ROWS: dim_b_rows = cfg_data;
                    CFG_B_COLS: dim_b_cols = cfg_data;
                    CFG_MODE:   prod_mode  = cfg_data[0];
                    default:    ;
                endcase
            end

            // input beat
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_WR_A:    copy_a[row_index][col_index] = element_in;
                    OP_WR_B:    copy_b[row_index][col_index] = element_in;
                    OP_COMPUTE: predict_compute();
                    default:    ;
                endcase
            end

            // result beat
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing owed, expected none, actual %0h",
                             $time, element_out);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("element_out", want.element, element_out);
                    check_field("out_row", want.row, out_row);
                    check_field("out_col", want.col, out_col);
                    check_field("status", want.err, status);
                    check_field("last_flag", want.last_beat, last_flag);
                end
            end

            results_pending = owed_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix sum / product engine. A short directed
// run covers wrap-around, the unused opcode and the dimension errors, then
// random phases each set a shape and mode and send element loads and
// computes, with random gaps on the input side and random stalls on the
// result side. Checking is done by the checker instance.
// ----------------------------------------------------------------------------

module tb_top;

    import mame_pkg::*;

    localparam int         MAX_DIM        = 8;
    localparam int         TARGET_ITEMS   = 430;
    localparam int         MAX_IDLE       = 11;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic        [2:0]        cfg_index;
    logic        [DIM_W-1:0]  cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic        [1:0]        opcode;
    logic        [IDX_W-1:0]  row_index;
    logic        [IDX_W-1:0]  col_index;
    logic signed [DATA_W-1:0] element_in;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] element_out;
    logic        [IDX_W-1:0]  out_row;
    logic        [IDX_W-1:0]  out_col;
    logic                     status;
    logic                     last_flag;

    int mismatch_count;
    int results_pending;

    // idle limits of the two sides, changed per phase
    int tx_max = 0;
    int rx_max = 0;
    int item_count = 0;

    // cells loaded so far, so a compute never reads an unwritten one
    bit a_loaded [MAX_DIM][MAX_DIM];
    bit b_loaded [MAX_DIM][MAX_DIM];

    // current shape as written to the block
    logic [DIM_W-1:0] shape_a_rows = DIM_W'(1);
    logic [DIM_W-1:0] shape_a_cols = DIM_W'(1);
    logic [DIM_W-1:0] shape_b_rows = DIM_W'(1);
    logic [DIM_W-1:0] shape_b_cols = DIM_W'(1);

    matrix_add_multiply_engine_unit #(
        .MAX_DIM (MAX_DIM)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .row_index   (row_index),
        .col_index   (col_index),
        .element_in  (element_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element_out (element_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .status      (status),
        .last_flag   (last_flag)
    );

    matrix_result_checker #(
        .MAX_DIM (MAX_DIM)
    ) result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .row_index       (row_index),
        .col_index       (col_index),
        .element_in      (element_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .element_out     (element_out),
        .out_row         (out_row),
        .out_col         (out_col),
        .status          (status),
        .last_flag       (last_flag),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int fill_extent(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // mostly small shapes, now and then zero or at or past the store size
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return DIM_W'($urandom_range(MAX_DIM, 15));
        if (r <= 3)
            return DIM_W'($urandom_range(4, MAX_DIM));
        return DIM_W'($urandom_range(1, 3));
    endfunction

    // same effective size, sometimes spelled as a saturating value
    function automatic logic [DIM_W-1:0] alias_dim(input logic [DIM_W-1:0] v);
        if (v >= MAX_DIM && $urandom_range(0, 1) == 1)
            return DIM_W'($urandom_range(MAX_DIM, 15));
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [DIM_W-1:0] d);
        if (d == 0 || $urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(0, MAX_DIM - 1));
        return IDX_W'($urandom_range(0, fill_extent(d) - 1));
    endfunction

    function automatic logic [DATA_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            4:       return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    // one input beat, after a random gap
    task automatic send_beat(input logic [1:0] op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        row_index  <= r;
        col_index  <= c;
        element_in <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_WR_A)
            a_loaded[r][c] = 1'b1;
        else if (op == OP_WR_B)
            b_loaded[r][c] = 1'b1;
        if (op != OP_UNUSED)
            item_count++;
    endtask

    // hold the sender until every owed result is out and the block is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // all five registers, written only while the block is idle
    task automatic set_shape(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                             input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc,
                             input logic mode);
        logic [2:0]       reg_sel [5];
        logic [DIM_W-1:0] reg_val [5];
        reg_sel = '{CFG_A_ROWS, CFG_A_COLS, CFG_B_ROWS, CFG_B_COLS, CFG_MODE};
        reg_val = '{ar, ac, br, bc, {{(DIM_W-1){1'b0}}, mode}};
        drain_results();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_sel[i];
            cfg_data  <= reg_val[i];
            @(posedge clk);
        end
        cfg_we       <= 1'b0;
        shape_a_rows = ar;
        shape_a_cols = ac;
        shape_b_rows = br;
        shape_b_cols = bc;
    endtask

    // load every cell the shape can touch that was never loaded, then compute
    task automatic run_compute();
        for (int i = 0; i < fill_extent(shape_a_rows); i++)
            for (int j = 0; j < fill_extent(shape_a_cols); j++)
                if (!a_loaded[i][j])
                    send_beat(OP_WR_A, IDX_W'(i), IDX_W'(j), random_element());
        for (int i = 0; i < fill_extent(shape_b_rows); i++)
            for (int j = 0; j < fill_extent(shape_b_cols); j++)
                if (!b_loaded[i][j])
                    send_beat(OP_WR_B, IDX_W'(i), IDX_W'(j), random_element());
        send_beat(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                  $urandom);
    endtask

    task automatic random_phase();
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] br;
        logic [DIM_W-1:0] bc;
        logic             mode;
        logic [1:0]       op;
        int               n_items;
        mode = 1'($urandom_range(0, 1));
        ar   = pick_dim();
        ac   = pick_dim();
        br   = pick_dim();
        bc   = pick_dim();
        // most phases use a shape that suits the mode
        if ($urandom_range(0, 7) != 0)
        begin
            if (mode == MODE_SUM)
            begin
                br = alias_dim(ar);
                bc = alias_dim(ac);
            end
            else
                br = alias_dim(ac);
        end
        set_shape(ar, ac, br, bc, mode);
        tx_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
        rx_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
        n_items = $urandom_range(6, 24);
        repeat (n_items)
        begin
            case ($urandom_range(0, 15))
                0:
                    send_beat(OP_UNUSED, IDX_W'($urandom_range(0, 7)),
                              IDX_W'($urandom_range(0, 7)), $urandom);
                1, 2:
                begin
                    if ($urandom_range(0, 7) == 0)
                        drain_results();
                    run_compute();
                end
                default:
                begin
                    op = $urandom_range(0, 1) ? OP_WR_B : OP_WR_A;
                    if (op == OP_WR_A)
                        send_beat(op, pick_index(shape_a_rows), pick_index(shape_a_cols),
                                  random_element());
                    else
                        send_beat(op, pick_index(shape_b_rows), pick_index(shape_b_cols),
                                  random_element());
                end
            endcase
        end
    endtask

    // result side: random stalls after beats and now and then while idle
    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
            else if ((out_valid && !out_stall) || $urandom_range(0, 15) == 0)
            begin
                hold = $urandom_range(0, rx_max);
                if (hold > 0)
                    out_stall <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_WR_A;
        row_index  <= '0;
        col_index  <= '0;
        element_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shape is 1x1 sum; largest positive plus one wraps
        send_beat(OP_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_beat(OP_WR_B, 3'd0, 3'd0, 32'h0000_0001);
        run_compute();
        // unused opcode with every field at its top value changes nothing
        send_beat(OP_UNUSED, '1, '1, '1);
        run_compute();

        tx_max = MAX_IDLE;
        rx_max = MAX_IDLE;
        // corner cells, outside the current shape
        send_beat(OP_WR_A, 3'd7, 3'd7, 32'h8000_0000);
        send_beat(OP_WR_B, 3'd7, 3'd7, 32'hffff_ffff);

        // row times column, most negative squared wraps to zero
        set_shape(4'd1, 4'd2, 4'd2, 4'd1, MODE_PROD);
        send_beat(OP_WR_A, 3'd0, 3'd1, 32'h8000_0000);
        send_beat(OP_WR_B, 3'd1, 3'd0, 32'h8000_0000);
        run_compute();

        // zero dimension, sum shapes that differ, product inner size differs
        set_shape(4'd0, 4'd1, 4'd1, 4'd1, MODE_SUM);
        run_compute();
        set_shape(4'd2, 4'd1, 4'd1, 4'd1, MODE_SUM);
        run_compute();
        set_shape(4'd1, 4'd2, 4'd1, 4'd1, MODE_PROD);
        run_compute();
        // saturated a_cols still disagrees with b_rows
        set_shape(4'd15, 4'd15, 4'd1, 4'd1, MODE_PROD);
        run_compute();

        while (item_count < TARGET_ITEMS)
            random_phase();

        drain_results();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/mame_pkg.sv
src/mame_mem.sv
src/mame_seq.sv
src/mame_dp.sv
src/matrix_add_multiply_engine_unit.sv
tb/matrix_result_checker.sv
tb/tb_top.sv
